// ----- hdl/ghps_pkg.sv -----
// Shared types and constants of the grid heading path search block.
package ghps_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] MODE_DFS = 2'd0;
    localparam logic [1:0] MODE_BFS = 2'd1;
    localparam logic [1:0] MODE_UCS = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    localparam logic [1:0] MODE_RESET = MODE_UCS;
    localparam logic [5:0] DIM_RESET  = 6'd32;

    localparam logic [1:0] ACT_FWD   = 2'd0;
    localparam logic [1:0] ACT_RIGHT = 2'd1;
    localparam logic [1:0] ACT_LEFT  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [7:0] TER_T = 8'h54;
    localparam logic [7:0] TER_A = 8'h41;
    localparam logic [7:0] TER_B = 8'h42;
    localparam logic [7:0] TER_P = 8'h50;
    localparam logic [7:0] TER_M = 8'h4D;
    localparam logic [7:0] TER_D = 8'h44;

    localparam int         EPOCH_W     = 4;
    localparam logic [3:0] EPOCH_FIRST = 4'd1;
    localparam logic [3:0] EPOCH_LAST  = 4'd15;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PLAN_RD,
        ST_CLEAR,
        ST_LOOP,
        ST_POP_LAST,
        ST_SIFT_A,
        ST_SIFT_B,
        ST_SIFT_C,
        ST_MARK,
        ST_RD_RIGHT,
        ST_RD_LEFT,
        ST_RD_FWD,
        ST_KIDS,
        ST_PUSH,
        ST_UP_A,
        ST_UP_B,
        ST_NEXT,
        ST_TOP,
        ST_TR_A,
        ST_TR_B,
        ST_DONE
    } state_t;

    function automatic logic is_obstacle(input logic [7:0] t);
        return (t == TER_P) || (t == TER_M) || (t == TER_D);
    endfunction

    function automatic logic [3:0] step_cost(input logic [7:0] t);
        logic [3:0] c;
        case (t)
            TER_T:   c = 4'd2;
            TER_A:   c = 4'd10;
            TER_B:   c = 4'd5;
            default: c = 4'd1;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/ghps_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module ghps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/grid_heading_path_search.sv -----
// Top level of the grid heading path search block: map store, search sequencer and plan store.
//
// One request is taken at a time. A map write goes from acceptance to the result state, and a
// plan read passes through a plan-store read state first. A search runs as a sequencer over
// five RAMs (terrain, closed marks, open list, node store, plan store), each with a registered
// read port. In uniform-cost mode the open list is a binary heap, each push climbing and each
// pop sinking it level by level. Tracing the plan back walks the node store one step at a time.
// The closed marks carry a 4-bit search epoch; on the first search after reset and on every
// fifteenth search after that, a clearing pass over all 4*max(GRID_SIZE,32)^2 closed-mark
// entries (4096 at the defaults) runs first. Result registers hold the finished result while
// the next request is taken.
module grid_heading_path_search #(
    parameter int GRID_SIZE  = 32,
    parameter int OPEN_DEPTH = 4096,
    parameter int PLAN_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [4:0]  row,
    input  logic [4:0]  column,
    input  logic [1:0]  heading,
    input  logic [4:0]  dest_row,
    input  logic [4:0]  dest_col,
    input  logic [7:0]  terrain_code,
    input  logic [9:0]  step_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [10:0] plan_length,
    output logic [1:0]  action,
    output logic        overflow,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import ghps_pkg::*;

    localparam int SPAN       = (GRID_SIZE > 32) ? GRID_SIZE : 32;
    localparam int CW         = $clog2(SPAN);
    localparam int RW         = CW + 2;
    localparam int NODE_DEPTH = 4 * OPEN_DEPTH;
    localparam int NW         = $clog2(NODE_DEPTH);
    localparam int OW         = $clog2(OPEN_DEPTH);
    localparam int KW         = $clog2(10 * NODE_DEPTH + 11);
    localparam int SW         = $clog2(3 * NODE_DEPTH + 2);
    localparam int PW         = $clog2(PLAN_DEPTH);
    localparam int LW         = $clog2(PLAN_DEPTH + 1);
    localparam int XW         = ((LW > 10) ? LW : 10) + 1;
    localparam int TDEPTH     = GRID_SIZE * GRID_SIZE;
    localparam int TW         = $clog2(TDEPTH);
    localparam int CDEPTH     = SPAN * SPAN * 4;
    localparam int CIW        = $clog2(CDEPTH);

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] c;
        logic [1:0]    h;
        logic [1:0]    act;
        logic [KW-1:0] cost;
        logic [NW-1:0] par;
        logic [SW-1:0] seq;
    } ent_t;

    localparam int EW = $bits(ent_t);

    function automatic logic ent_less(input ent_t a, input ent_t b);
        return (a.cost < b.cost) || ((a.cost == b.cost) && (a.seq < b.seq));
    endfunction

    function automatic logic [CIW-1:0] cidx(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [1:0] h);
        return (CIW'(r) * CIW'(SPAN) + CIW'(c)) * CIW'(4) + CIW'(h);
    endfunction

    // control state
    state_t              state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [5:0]          rows_reg, rows_next;
    logic [5:0]          cols_reg, cols_next;
    logic                found_reg, found_next;
    logic                ovf_reg, ovf_next;
    logic [LW-1:0]       plan_cnt_reg, plan_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [OW:0]         open_cnt_reg, open_cnt_next;
    logic [NW:0]         node_cnt_reg, node_cnt_next;

    // payload
    logic                res_found_reg, res_found_next;
    logic [10:0]         res_len_reg, res_len_next;
    logic [1:0]          res_act_reg, res_act_next;
    logic                res_ovf_reg, res_ovf_next;
    logic [1:0]          act_reg, act_next;
    logic                hit_reg, hit_next;
    logic [CIW-1:0]      clr_reg, clr_next;
    ent_t                cur_reg, cur_next;
    logic [4:0]          dest_r_reg, dest_r_next;
    logic [4:0]          dest_c_reg, dest_c_next;
    logic [OW-1:0]       head_reg, head_next;
    logic [SW-1:0]       seq_reg, seq_next;
    logic [OW-1:0]       hi_reg, hi_next;
    ent_t                last_reg, last_next;
    ent_t                lch_reg, lch_next;
    ent_t                pe_reg, pe_next;
    logic [2:0]          kid_ok_reg, kid_ok_next;
    logic [1:0]          kid_sel_reg, kid_sel_next;
    logic [CW-1:0]       fwd_r_reg, fwd_r_next;
    logic [CW-1:0]       fwd_c_reg, fwd_c_next;
    logic [3:0]          fwd_cost_reg, fwd_cost_next;
    logic [1:0]          tr_act_reg, tr_act_next;
    logic [NW-1:0]       tr_par_reg, tr_par_next;
    logic [LW-1:0]       len_reg, len_next;

    // memory ports
    logic                t_we;
    logic [TW-1:0]       t_waddr, t_raddr;
    logic [7:0]          t_wdata, t_rdata;
    logic                c_we;
    logic [CIW-1:0]      c_waddr, c_raddr;
    logic [EPOCH_W-1:0]  c_wdata, c_rdata;
    logic                o_we;
    logic [OW-1:0]       o_waddr, o_raddr;
    logic [EW-1:0]       o_wdata, o_rdata;
    logic                n_we;
    logic [NW-1:0]       n_waddr, n_raddr;
    logic [NW+1:0]       n_wdata, n_rdata;
    logic                p_we;
    logic [PW-1:0]       p_waddr, p_raddr;
    logic [1:0]          p_wdata, p_rdata;

    // datapath helpers
    ent_t                rd_ent;
    ent_t                root_ent;
    ent_t                kid_ent;
    ent_t                sift_ch;
    logic [OW+1:0]       l_idx;
    logic [OW+1:0]       sift_s;
    logic                l_has;
    logic                r_has;
    logic [OW-1:0]       up_par;
    logic [OW:0]         tail_sum;
    logic [OW-1:0]       tail_addr;
    logic [OW-1:0]       top_addr;
    logic                nxt_ok;
    logic [1:0]          nxt_sel;
    logic [RW-1:0]       rows_eff;
    logic [RW-1:0]       cols_eff;
    logic [CW:0]         nr;
    logic [CW:0]         nc;
    logic                fwd_blocked;
    logic                at_dest;

    ghps_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_terrain (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
    );

    ghps_ram #(.WIDTH(EPOCH_W), .DEPTH(CDEPTH)) u_closed (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
    );

    ghps_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_open (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
    );

    ghps_ram #(.WIDTH(NW + 2), .DEPTH(NODE_DEPTH)) u_node (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata)
    );

    ghps_ram #(.WIDTH(2), .DEPTH(PLAN_DEPTH)) u_plan (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
    );

    always_comb
    begin
        rd_ent = ent_t'(o_rdata);

        root_ent.r    = CW'(row);
        root_ent.c    = CW'(column);
        root_ent.h    = heading;
        root_ent.act  = ACT_NONE;
        root_ent.cost = '0;
        root_ent.par  = '0;
        root_ent.seq  = '0;

        kid_ent      = cur_reg;
        kid_ent.par  = NW'(node_cnt_reg);
        kid_ent.seq  = seq_reg;
        case (kid_sel_reg)
            2'd0:
            begin
                kid_ent.h    = cur_reg.h + 2'd1;
                kid_ent.act  = ACT_RIGHT;
                kid_ent.cost = cur_reg.cost + KW'(1);
            end
            2'd1:
            begin
                kid_ent.h    = cur_reg.h + 2'd3;
                kid_ent.act  = ACT_LEFT;
                kid_ent.cost = cur_reg.cost + KW'(1);
            end
            default:
            begin
                kid_ent.r    = fwd_r_reg;
                kid_ent.c    = fwd_c_reg;
                kid_ent.act  = ACT_FWD;
                kid_ent.cost = cur_reg.cost + KW'(fwd_cost_reg);
            end
        endcase

        case (kid_sel_reg)
            2'd0:
            begin
                nxt_ok  = kid_ok_reg[1] || kid_ok_reg[2];
                nxt_sel = kid_ok_reg[1] ? 2'd1 : 2'd2;
            end
            2'd1:
            begin
                nxt_ok  = kid_ok_reg[2];
                nxt_sel = 2'd2;
            end
            default:
            begin
                nxt_ok  = 1'b0;
                nxt_sel = 2'd2;
            end
        endcase

        l_idx  = ((OW + 2)'(hi_reg) << 1) | (OW + 2)'(1);
        l_has  = l_idx < (OW + 2)'(open_cnt_reg);
        r_has  = (l_idx + (OW + 2)'(1)) < (OW + 2)'(open_cnt_reg);
        up_par = OW'((hi_reg - OW'(1)) >> 1);

        if ((state_reg == ST_SIFT_C) && ent_less(rd_ent, lch_reg))
        begin
            sift_ch = rd_ent;
            sift_s  = l_idx + (OW + 2)'(1);
        end
        else if (state_reg == ST_SIFT_C)
        begin
            sift_ch = lch_reg;
            sift_s  = l_idx;
        end
        else
        begin
            sift_ch = rd_ent;
            sift_s  = l_idx;
        end

        tail_sum = (OW + 1)'(head_reg) + open_cnt_reg;
        if (tail_sum >= (OW + 1)'(OPEN_DEPTH))
        begin
            tail_sum = tail_sum - (OW + 1)'(OPEN_DEPTH);
        end
        tail_addr = OW'(tail_sum);

        case (mode_reg)
            MODE_DFS: top_addr = OW'(open_cnt_reg - (OW + 1)'(1));
            MODE_BFS: top_addr = head_reg;
            default:  top_addr = '0;
        endcase

        rows_eff = (int'(rows_reg) > GRID_SIZE) ? RW'(GRID_SIZE) : RW'(rows_reg);
        cols_eff = (int'(cols_reg) > GRID_SIZE) ? RW'(GRID_SIZE) : RW'(cols_reg);

        nr          = (CW + 1)'(cur_reg.r);
        nc          = (CW + 1)'(cur_reg.c);
        fwd_blocked = 1'b0;
        case (cur_reg.h)
            2'd0:
            begin
                if (cur_reg.r == '0)
                    fwd_blocked = 1'b1;
                else
                    nr = nr - (CW + 1)'(1);
            end
            2'd1:    nc = nc + (CW + 1)'(1);
            2'd2:    nr = nr + (CW + 1)'(1);
            default:
            begin
                if (cur_reg.c == '0)
                    fwd_blocked = 1'b1;
                else
                    nc = nc - (CW + 1)'(1);
            end
        endcase
        if ((RW'(nr) >= rows_eff) || (RW'(nc) >= cols_eff))
        begin
            fwd_blocked = 1'b1;
        end

        at_dest = (cur_reg.r == CW'(dest_r_reg)) && (cur_reg.c == CW'(dest_c_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        plan_cnt_next  = plan_cnt_reg;
        out_valid_next = out_valid_reg;
        epoch_next     = epoch_reg;
        open_cnt_next  = open_cnt_reg;
        node_cnt_next  = node_cnt_reg;
        res_found_next = res_found_reg;
        res_len_next   = res_len_reg;
        res_act_next   = res_act_reg;
        res_ovf_next   = res_ovf_reg;
        act_next       = act_reg;
        hit_next       = hit_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        dest_r_next    = dest_r_reg;
        dest_c_next    = dest_c_reg;
        head_next      = head_reg;
        seq_next       = seq_reg;
        hi_next        = hi_reg;
        last_next      = last_reg;
        lch_next       = lch_reg;
        pe_next        = pe_reg;
        kid_ok_next    = kid_ok_reg;
        kid_sel_next   = kid_sel_reg;
        fwd_r_next     = fwd_r_reg;
        fwd_c_next     = fwd_c_reg;
        fwd_cost_next  = fwd_cost_reg;
        tr_act_next    = tr_act_reg;
        tr_par_next    = tr_par_reg;
        len_next       = len_reg;

        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        c_we    = 1'b0;
        c_waddr = '0;
        c_wdata = '0;
        c_raddr = '0;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_raddr = '0;
        n_we    = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        n_raddr = '0;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_raddr = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE: mode_next = cfg_data[1:0];
                REG_ROWS: rows_next = cfg_data;
                REG_COLS: cols_next = cfg_data;
                default:  ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = ACT_NONE;
                    case (cmd)
                        CMD_WRITE:
                        begin
                            if ((int'(row) < GRID_SIZE) && (int'(column) < GRID_SIZE))
                            begin
                                t_we    = 1'b1;
                                t_waddr = TW'(row) * TW'(GRID_SIZE) + TW'(column);
                                t_wdata = terrain_code;
                            end
                            state_next = ST_DONE;
                        end
                        CMD_SEARCH:
                        begin
                            plan_cnt_next = '0;
                            found_next    = 1'b0;
                            ovf_next      = 1'b0;
                            if ((mode_reg != MODE_DFS) && (mode_reg != MODE_BFS)
                                && (mode_reg != MODE_UCS))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cur_next      = root_ent;
                                dest_r_next   = dest_row;
                                dest_c_next   = dest_col;
                                o_we          = 1'b1;
                                o_waddr       = '0;
                                o_wdata       = root_ent;
                                open_cnt_next = (OW + 1)'(1);
                                head_next     = '0;
                                seq_next      = SW'(1);
                                node_cnt_next = '0;
                                if ((epoch_reg == '0) || (epoch_reg == EPOCH_LAST))
                                begin
                                    epoch_next = EPOCH_FIRST;
                                    clr_next   = '0;
                                    state_next = ST_CLEAR;
                                end
                                else
                                begin
                                    epoch_next = epoch_reg + EPOCH_W'(1);
                                    state_next = ST_LOOP;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            hit_next   = XW'(step_index) < XW'(plan_cnt_reg);
                            p_raddr    = PW'(XW'(plan_cnt_reg) - XW'(1) - XW'(step_index));
                            state_next = ST_PLAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PLAN_RD:
            begin
                act_next   = hit_reg ? p_rdata : ACT_NONE;
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                c_we     = 1'b1;
                c_waddr  = clr_reg;
                c_wdata  = '0;
                clr_next = clr_reg + CIW'(1);
                if (clr_reg == CIW'(CDEPTH - 1))
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (at_dest)
                begin
                    tr_act_next = cur_reg.act;
                    tr_par_next = cur_reg.par;
                    len_next    = '0;
                    state_next  = ST_TR_A;
                end
                else if (open_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    open_cnt_next = open_cnt_reg - (OW + 1)'(1);
                    case (mode_reg)
                        MODE_DFS:
                        begin
                            state_next = ST_MARK;
                        end
                        MODE_BFS:
                        begin
                            head_next  = (head_reg == OW'(OPEN_DEPTH - 1)) ? '0
                                                                            : head_reg + OW'(1);
                            state_next = ST_MARK;
                        end
                        default:
                        begin
                            o_raddr    = OW'(open_cnt_reg - (OW + 1)'(1));
                            state_next = ST_POP_LAST;
                        end
                    endcase
                end
            end
            ST_POP_LAST:
            begin
                last_next = rd_ent;
                hi_next   = '0;
                if (open_cnt_reg == '0)
                    state_next = ST_MARK;
                else
                    state_next = ST_SIFT_A;
            end
            ST_SIFT_A:
            begin
                if (!l_has)
                begin
                    o_we       = 1'b1;
                    o_waddr    = hi_reg;
                    o_wdata    = last_reg;
                    state_next = ST_MARK;
                end
                else
                begin
                    o_raddr    = OW'(l_idx);
                    state_next = ST_SIFT_B;
                end
            end
            ST_SIFT_B, ST_SIFT_C:
            begin
                if ((state_reg == ST_SIFT_B) && r_has)
                begin
                    lch_next   = rd_ent;
                    o_raddr    = OW'(l_idx + (OW + 2)'(1));
                    state_next = ST_SIFT_C;
                end
                else if (ent_less(sift_ch, last_reg))
                begin
                    o_we       = 1'b1;
                    o_waddr    = hi_reg;
                    o_wdata    = sift_ch;
                    hi_next    = OW'(sift_s);
                    state_next = ST_SIFT_A;
                end
                else
                begin
                    o_we       = 1'b1;
                    o_waddr    = hi_reg;
                    o_wdata    = last_reg;
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                c_we       = 1'b1;
                c_waddr    = cidx(cur_reg.r, cur_reg.c, cur_reg.h);
                c_wdata    = epoch_reg;
                c_raddr    = cidx(cur_reg.r, cur_reg.c, cur_reg.h + 2'd1);
                state_next = ST_RD_RIGHT;
            end
            ST_RD_RIGHT:
            begin
                kid_ok_next[0] = c_rdata != epoch_reg;
                c_raddr        = cidx(cur_reg.r, cur_reg.c, cur_reg.h + 2'd3);
                state_next     = ST_RD_LEFT;
            end
            ST_RD_LEFT:
            begin
                kid_ok_next[1] = c_rdata != epoch_reg;
                if (fwd_blocked)
                begin
                    kid_ok_next[2] = 1'b0;
                    state_next     = ST_KIDS;
                end
                else
                begin
                    fwd_r_next = CW'(nr);
                    fwd_c_next = CW'(nc);
                    t_raddr    = TW'(nr) * TW'(GRID_SIZE) + TW'(nc);
                    c_raddr    = cidx(CW'(nr), CW'(nc), cur_reg.h);
                    state_next = ST_RD_FWD;
                end
            end
            ST_RD_FWD:
            begin
                kid_ok_next[2] = !is_obstacle(t_rdata) && (c_rdata != epoch_reg);
                fwd_cost_next  = step_cost(t_rdata);
                state_next     = ST_KIDS;
            end
            ST_KIDS:
            begin
                if (kid_ok_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else if (node_cnt_reg >= (NW + 1)'(NODE_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    n_we         = 1'b1;
                    n_waddr      = NW'(node_cnt_reg);
                    n_wdata      = {cur_reg.par, cur_reg.act};
                    kid_sel_next = kid_ok_reg[0] ? 2'd0 : (kid_ok_reg[1] ? 2'd1 : 2'd2);
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (open_cnt_reg >= (OW + 1)'(OPEN_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    seq_next      = seq_reg + SW'(1);
                    open_cnt_next = open_cnt_reg + (OW + 1)'(1);
                    if ((mode_reg == MODE_DFS) || (mode_reg == MODE_BFS))
                    begin
                        o_we    = 1'b1;
                        o_waddr = (mode_reg == MODE_DFS) ? OW'(open_cnt_reg) : tail_addr;
                        o_wdata = kid_ent;
                        if (nxt_ok)
                        begin
                            kid_sel_next = nxt_sel;
                        end
                        else
                        begin
                            node_cnt_next = node_cnt_reg + (NW + 1)'(1);
                            state_next    = ST_NEXT;
                        end
                    end
                    else
                    begin
                        pe_next    = kid_ent;
                        hi_next    = OW'(open_cnt_reg);
                        state_next = ST_UP_A;
                    end
                end
            end
            ST_UP_A, ST_UP_B:
            begin
                if ((state_reg == ST_UP_A) && (hi_reg != '0))
                begin
                    o_raddr    = up_par;
                    state_next = ST_UP_B;
                end
                else if ((state_reg == ST_UP_B) && ent_less(pe_reg, rd_ent))
                begin
                    o_we       = 1'b1;
                    o_waddr    = hi_reg;
                    o_wdata    = rd_ent;
                    hi_next    = up_par;
                    state_next = ST_UP_A;
                end
                else
                begin
                    o_we    = 1'b1;
                    o_waddr = hi_reg;
                    o_wdata = pe_reg;
                    if (nxt_ok)
                    begin
                        kid_sel_next = nxt_sel;
                        state_next   = ST_PUSH;
                    end
                    else
                    begin
                        node_cnt_next = node_cnt_reg + (NW + 1)'(1);
                        state_next    = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                if (open_cnt_reg != '0)
                begin
                    o_raddr    = top_addr;
                    state_next = ST_TOP;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_TOP:
            begin
                cur_next   = rd_ent;
                state_next = ST_LOOP;
            end
            ST_TR_A:
            begin
                if (tr_act_reg == ACT_NONE)
                begin
                    found_next    = 1'b1;
                    plan_cnt_next = len_reg;
                    state_next    = ST_DONE;
                end
                else if (len_reg == LW'(PLAN_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    p_we       = 1'b1;
                    p_waddr    = PW'(len_reg);
                    p_wdata    = tr_act_reg;
                    len_next   = len_reg + LW'(1);
                    n_raddr    = tr_par_reg;
                    state_next = ST_TR_B;
                end
            end
            ST_TR_B:
            begin
                tr_act_next = n_rdata[1:0];
                tr_par_next = n_rdata[NW+1:2];
                state_next  = ST_TR_A;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_found_next = found_reg;
                    res_len_next   = 11'(plan_cnt_reg);
                    res_act_next   = act_reg;
                    res_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RESET;
            rows_reg      <= DIM_RESET;
            cols_reg      <= DIM_RESET;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            plan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            epoch_reg     <= '0;
            open_cnt_reg  <= '0;
            node_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            plan_cnt_reg  <= plan_cnt_next;
            out_valid_reg <= out_valid_next;
            epoch_reg     <= epoch_next;
            open_cnt_reg  <= open_cnt_next;
            node_cnt_reg  <= node_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg <= res_found_next;
        res_len_reg   <= res_len_next;
        res_act_reg   <= res_act_next;
        res_ovf_reg   <= res_ovf_next;
        act_reg       <= act_next;
        hit_reg       <= hit_next;
        clr_reg       <= clr_next;
        cur_reg       <= cur_next;
        dest_r_reg    <= dest_r_next;
        dest_c_reg    <= dest_c_next;
        head_reg      <= head_next;
        seq_reg       <= seq_next;
        hi_reg        <= hi_next;
        last_reg      <= last_next;
        lch_reg       <= lch_next;
        pe_reg        <= pe_next;
        kid_ok_reg    <= kid_ok_next;
        kid_sel_reg   <= kid_sel_next;
        fwd_r_reg     <= fwd_r_next;
        fwd_c_reg     <= fwd_c_next;
        fwd_cost_reg  <= fwd_cost_next;
        tr_act_reg    <= tr_act_next;
        tr_par_reg    <= tr_par_next;
        len_reg       <= len_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = res_found_reg;
    assign plan_length = res_len_reg;
    assign action      = res_act_reg;
    assign overflow    = res_ovf_reg;

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_cnt_reg <= (OW + 1)'(OPEN_DEPTH))
        else $error("open list count beyond its depth");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_cnt_reg <= (NW + 1)'(NODE_DEPTH))
        else $error("node store count beyond its depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(found_reg && ovf_reg))
        else $error("found and overflow set together");

    a_plan_found: assert property (@(posedge clk) disable iff (!rst_n)
        (plan_cnt_reg != '0) |-> found_reg)
        else $error("plan length held without a found search");

    a_clear_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (epoch_reg == EPOCH_FIRST))
        else $error("clearing pass with a stale epoch");

endmodule

// ----- verif/testbench.sv -----
// Testbench of the grid heading path search block: map fill, directed rows, random phases.
module testbench;
    import ghps_pkg::*;

    typedef struct packed {
        logic        found;
        logic [10:0] plan_length;
        logic [1:0]  action;
        logic        overflow;
    } status_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [5:0]  reg_val;
        logic [1:0]  cmd;
        logic [4:0]  row;
        logic [4:0]  column;
        logic [1:0]  heading;
        logic [4:0]  dest_row;
        logic [4:0]  dest_col;
        logic [7:0]  terrain_code;
        logic [9:0]  step_index;
        bit          typed;
        status_t     typed_status;
    } request_t;

    typedef struct {
        int unsigned     r, c, h;
        logic [1:0]      act;
        int unsigned     cost, par;
        longint unsigned sq;
    } node_t;

    localparam int unsigned NO_PARENT  = 32'hFFFF_FFFF;
    localparam int unsigned FRONT_MAX  = 4096;
    localparam int unsigned TRACE_MAX  = 16384;
    localparam int unsigned PLAN_MAX   = 1024;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  cmd, heading, action;
    logic [4:0]  row, column, dest_row, dest_col;
    logic [7:0]  terrain_code;
    logic [9:0]  step_index;
    logic        found, overflow;
    logic [10:0] plan_length;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    grid_heading_path_search i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .row(row), .column(column), .heading(heading),
        .dest_row(dest_row), .dest_col(dest_col),
        .terrain_code(terrain_code), .step_index(step_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .plan_length(plan_length), .action(action), .overflow(overflow),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [7:0]      map_mirror [1024];
    bit              closed_mark [4096];
    node_t           frontier [FRONT_MAX];
    int unsigned     fr_head, fr_cnt;
    longint unsigned fr_seq;
    int unsigned     trace_par [TRACE_MAX];
    logic [1:0]      trace_act [TRACE_MAX];
    int unsigned     trace_cnt;
    logic [1:0]      plan_mirror [PLAN_MAX];
    int unsigned     plan_cnt;
    bit              found_m, overflow_m;
    logic [1:0]      mode_m;
    logic [5:0]      rows_m, cols_m;

    status_t         pending_status [$];
    request_t        directed [$];
    int              errors, results_seen, idle_mode, hold_left;
    bit              held;

    function automatic bit frontier_push(node_t e);
        if (fr_cnt >= FRONT_MAX)
            return 0;
        e.sq = fr_seq;
        fr_seq++;
        if (mode_m == MODE_BFS)
            frontier[(fr_head + fr_cnt) % FRONT_MAX] = e;
        else
            frontier[fr_cnt] = e;
        fr_cnt++;
        return 1;
    endfunction

    function automatic int unsigned frontier_top();
        int unsigned best;
        if (mode_m == MODE_DFS)
            return fr_cnt - 1;
        if (mode_m == MODE_BFS)
            return fr_head;
        best = 0;
        for (int unsigned i = 1; i < fr_cnt; i++)
            if (frontier[i].cost < frontier[best].cost ||
                (frontier[i].cost == frontier[best].cost && frontier[i].sq < frontier[best].sq))
                best = i;
        return best;
    endfunction

    task automatic frontier_pop();
        int unsigned t;
        t = frontier_top();
        if (mode_m == MODE_BFS)
            fr_head = (fr_head + 1) % FRONT_MAX;
        else if (mode_m != MODE_DFS)
            frontier[t] = frontier[fr_cnt - 1];
        fr_cnt--;
    endtask

    function automatic int unsigned mark_index(int unsigned r, int unsigned c, int unsigned h);
        return ((r * 32) + c) * 4 + (h % 4);
    endfunction

    task automatic plan_search(int unsigned sr, int unsigned sc, int unsigned sh,
                               int unsigned dr, int unsigned dc);
        int unsigned rows, cols, n, nr, nc, len, pos, p;
        bit          blocked;
        logic [7:0]  t;
        logic [1:0]  a;
        node_t       cur, k;
        node_t       kids [3];
        rows = (rows_m > 32) ? 32 : rows_m;
        cols = (cols_m > 32) ? 32 : cols_m;
        plan_cnt = 0;
        found_m = 0;
        overflow_m = 0;
        if (mode_m > MODE_UCS)
            return;
        foreach (closed_mark[i])
            closed_mark[i] = 0;
        fr_head = 0;
        fr_cnt = 0;
        fr_seq = 0;
        trace_cnt = 0;
        cur = '{sr, sc, sh, ACT_NONE, 0, NO_PARENT, 0};
        void'(frontier_push(cur));
        while (fr_cnt > 0 && !(cur.r == dr && cur.c == dc))
        begin
            n = 0;
            nr = cur.r;
            nc = cur.c;
            blocked = 0;
            frontier_pop();
            closed_mark[mark_index(cur.r, cur.c, cur.h)] = 1;
            k = cur;
            k.h = (cur.h + 1) % 4;
            if (!closed_mark[mark_index(cur.r, cur.c, k.h)])
            begin
                k.act = ACT_RIGHT;
                k.cost = cur.cost + 1;
                kids[n] = k;
                n++;
            end
            k = cur;
            k.h = (cur.h + 3) % 4;
            if (!closed_mark[mark_index(cur.r, cur.c, k.h)])
            begin
                k.act = ACT_LEFT;
                k.cost = cur.cost + 1;
                kids[n] = k;
                n++;
            end
            case (cur.h)
                0: if (nr == 0) blocked = 1; else nr--;
                1: nc++;
                2: nr++;
                default: if (nc == 0) blocked = 1; else nc--;
            endcase
            if (!blocked && (nr >= rows || nc >= cols))
                blocked = 1;
            if (!blocked)
            begin
                t = map_mirror[nr * 32 + nc];
                if (!(t == TER_P || t == TER_M || t == TER_D) &&
                    !closed_mark[mark_index(nr, nc, cur.h)])
                begin
                    k = cur;
                    k.r = nr;
                    k.c = nc;
                    k.act = ACT_FWD;
                    k.cost = cur.cost + ((t == TER_T) ? 2 : (t == TER_A) ? 10 :
                                         (t == TER_B) ? 5 : 1);
                    kids[n] = k;
                    n++;
                end
            end
            if (n > 0)
            begin
                if (trace_cnt >= TRACE_MAX)
                begin
                    overflow_m = 1;
                    return;
                end
                trace_par[trace_cnt] = cur.par;
                trace_act[trace_cnt] = cur.act;
                for (int unsigned i = 0; i < n; i++)
                begin
                    kids[i].par = trace_cnt;
                    if (!frontier_push(kids[i]))
                    begin
                        overflow_m = 1;
                        return;
                    end
                end
                trace_cnt++;
            end
            if (fr_cnt > 0)
                cur = frontier[frontier_top()];
        end
        if (!(cur.r == dr && cur.c == dc))
            return;
        len = 0;
        a = cur.act;
        p = cur.par;
        while (a != ACT_NONE && p < trace_cnt)
        begin
            len++;
            a = trace_act[p];
            p = trace_par[p];
        end
        if (len > PLAN_MAX)
        begin
            overflow_m = 1;
            return;
        end
        pos = len;
        a = cur.act;
        p = cur.par;
        while (a != ACT_NONE && p < trace_cnt && pos > 0)
        begin
            pos--;
            plan_mirror[pos] = a;
            a = trace_act[p];
            p = trace_par[p];
        end
        plan_cnt = len;
        found_m = 1;
    endtask

    task automatic apply_request(request_t q, output status_t s);
        logic [1:0] a;
        a = ACT_NONE;
        if (q.cmd == CMD_WRITE)
            map_mirror[q.row * 32 + q.column] = q.terrain_code;
        else if (q.cmd == CMD_SEARCH)
            plan_search(q.row, q.column, q.heading, q.dest_row, q.dest_col);
        else if (q.cmd == CMD_READ && q.step_index < plan_cnt)
            a = plan_mirror[q.step_index];
        s = '{found_m, plan_cnt[10:0], a, overflow_m};
    endtask

    function automatic request_t make_req(logic [1:0] c, int r, int col, int h, int dr, int dc,
                                          int code, int idx);
        request_t q;
        q = '{default: '0};
        q.cmd = c;
        q.row = r;
        q.column = col;
        q.heading = h;
        q.dest_row = dr;
        q.dest_col = dc;
        q.terrain_code = code;
        q.step_index = idx;
        return q;
    endfunction

    function automatic request_t make_typed(request_t q, status_t s);
        q.typed = 1;
        q.typed_status = s;
        return q;
    endfunction

    function automatic request_t make_cfg(logic [1:0] idx, int val);
        request_t q;
        q = '{default: '0};
        q.is_cfg = 1;
        q.reg_idx = idx;
        q.reg_val = val;
        return q;
    endfunction

    function automatic logic [7:0] pick_terrain();
        case ($urandom_range(0, 19))
            0: return TER_P;
            1: return TER_M;
            2: return TER_D;
            3, 6: return TER_T;
            4: return TER_A;
            5: return TER_B;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic write_register(request_t q);
        in_valid = 0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1;
        cfg_index = q.reg_idx;
        cfg_data = q.reg_val;
        @(negedge clk);
        cfg_we = 0;
        if (q.reg_idx == REG_MODE)
            mode_m = q.reg_val[1:0];
        else if (q.reg_idx == REG_ROWS)
            rows_m = q.reg_val;
        else if (q.reg_idx == REG_COLS)
            cols_m = q.reg_val;
    endtask

    task automatic issue_request(request_t q);
        status_t s;
        int      pct;
        if (q.is_cfg)
        begin
            write_register(q);
            return;
        end
        pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 13 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        cmd = q.cmd;
        row = q.row;
        column = q.column;
        heading = q.heading;
        dest_row = q.dest_row;
        dest_col = q.dest_col;
        terrain_code = q.terrain_code;
        step_index = q.step_index;
        do
            @(posedge clk);
        while (in_stall);
        apply_request(q, s);
        pending_status.push_back(q.typed ? q.typed_status : s);
        @(negedge clk);
    endtask

    task automatic random_phase(int count);
        request_t    q;
        int unsigned rr, cc, lim;
        int          searches, dice;
        bit          big;
        dice = $urandom_range(0, 9);
        if (dice == 0)
            issue_request(make_cfg(REG_ROWS, $urandom_range(0, 1)));
        else if (dice == 1)
            issue_request(make_cfg(REG_ROWS, $urandom_range(32, 63)));
        else
            issue_request(make_cfg(REG_ROWS, $urandom_range(2, 8)));
        dice = $urandom_range(0, 9);
        if (dice == 0)
            issue_request(make_cfg(REG_COLS, $urandom_range(0, 1)));
        else if (dice == 1)
            issue_request(make_cfg(REG_COLS, $urandom_range(32, 63)));
        else
            issue_request(make_cfg(REG_COLS, $urandom_range(2, 8)));
        issue_request(make_cfg(REG_MODE, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)));
        rr = (rows_m == 0) ? 1 : (rows_m > 32) ? 32 : rows_m;
        cc = (cols_m == 0) ? 1 : (cols_m > 32) ? 32 : cols_m;
        big = (rr > 8) || (cc > 8);
        searches = 0;
        for (int i = 0; i < count; i++)
        begin
            dice = $urandom_range(0, 99);
            if (dice < 25 && !(big && searches >= 2))
            begin
                q = make_req(CMD_SEARCH, $urandom_range(0, rr - 1), $urandom_range(0, cc - 1),
                             $urandom_range(0, 3), $urandom_range(0, rr - 1),
                             $urandom_range(0, cc - 1), $urandom_range(0, 255),
                             $urandom_range(0, 1023));
                if ($urandom_range(0, 9) == 0)
                begin
                    q.row = $urandom_range(0, 31);
                    q.column = $urandom_range(0, 31);
                end
                searches++;
            end
            else if (dice < 70)
            begin
                lim = (plan_cnt + 1 > 1023) ? 1023 : plan_cnt + 1;
                q = make_req(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 3), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 255),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, lim));
            end
            else if (dice < 90)
                q = make_req(CMD_WRITE, $urandom_range(0, rr - 1), $urandom_range(0, cc - 1),
                             $urandom_range(0, 3), $urandom_range(0, 31),
                             $urandom_range(0, 31), pick_terrain(), $urandom_range(0, 1023));
            else
            begin
                q = make_req($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 3), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 255),
                             $urandom_range(0, 1023));
                if (q.cmd == CMD_SEARCH && (big || rows_m == 0 || cols_m == 0))
                    q.cmd = CMD_READ;
            end
            issue_request(q);
        end
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        out_stall = 0;
        hold_left = 0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1;
                hold_left--;
            end
            else if (!held && results_seen >= 600)
            begin
                held = 1;
                hold_left = 300;
                out_stall = 1;
            end
            else
                out_stall = (idle_mode == 2 && $urandom_range(0, 99) < 76) ||
                            (idle_mode == 3 && $urandom_range(0, 99) < 13);
        end
    end

    always @(posedge clk)
    begin
        status_t want, got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{found, plan_length, action, overflow};
            results_seen++;
            if (pending_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result found=%0d len=%0d act=%0d ovf=%0d",
                             got.found, got.plan_length, got.action, got.overflow);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.found !== want.found || got.plan_length !== want.plan_length ||
                    got.action !== want.action || got.overflow !== want.overflow)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want found=%0d len=%0d act=%0d ovf=%0d, got %0d %0d %0d %0d",
                                 want.found, want.plan_length, want.action, want.overflow,
                                 got.found, got.plan_length, got.action, got.overflow);
                end
            end
        end
    end

    initial
    begin
        status_t idle_st, hit_st;
        rst_n = 0;
        in_valid = 0;
        cmd = CMD_WRITE;
        row = 0;
        column = 0;
        heading = 0;
        dest_row = 0;
        dest_col = 0;
        terrain_code = 0;
        step_index = 0;
        cfg_we = 0;
        cfg_index = REG_MODE;
        cfg_data = 0;
        errors = 0;
        results_seen = 0;
        idle_mode = 0;
        plan_cnt = 0;
        found_m = 0;
        overflow_m = 0;
        mode_m = MODE_RESET;
        rows_m = DIM_RESET;
        cols_m = DIM_RESET;
        idle_st = '{1'b0, 11'd0, ACT_NONE, 1'b0};
        hit_st = '{1'b1, 11'd0, ACT_NONE, 1'b0};

        directed.push_back(make_typed(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0), idle_st));
        directed.push_back(make_typed(make_req(2'd3, 31, 31, 3, 31, 31, 255, 1023), idle_st));
        directed.push_back(make_typed(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 1023), idle_st));
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++)
                directed.push_back(make_req(CMD_WRITE, r, c, $urandom_range(0, 3),
                                            $urandom_range(0, 31), $urandom_range(0, 31),
                                            pick_terrain(), $urandom_range(0, 1023)));
        directed.push_back(make_cfg(REG_ROWS, 4));
        directed.push_back(make_cfg(REG_COLS, 4));
        directed.push_back(make_typed(make_req(CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0), hit_st));
        directed.push_back(make_typed(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0), hit_st));
        directed.push_back(make_req(CMD_SEARCH, 0, 0, 1, 3, 3, 0, 0));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 1023));
        directed.push_back(make_cfg(REG_MODE, MODE_DFS));
        directed.push_back(make_req(CMD_SEARCH, 3, 3, 3, 0, 0, 0, 0));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 2));
        directed.push_back(make_cfg(REG_MODE, MODE_BFS));
        directed.push_back(make_req(CMD_SEARCH, 0, 3, 2, 3, 0, 0, 0));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(make_cfg(REG_MODE, 3));
        directed.push_back(make_typed(make_req(CMD_SEARCH, 0, 0, 0, 2, 2, 0, 0), idle_st));
        directed.push_back(make_cfg(REG_MODE, MODE_UCS));
        directed.push_back(make_cfg(REG_ROWS, 0));
        directed.push_back(make_typed(make_req(CMD_SEARCH, 0, 0, 0, 1, 1, 0, 0), idle_st));
        directed.push_back(make_cfg(2'd3, 63));
        directed.push_back(make_cfg(REG_ROWS, 1));
        directed.push_back(make_cfg(REG_COLS, 1));
        directed.push_back(make_req(CMD_SEARCH, 5, 5, 2, 0, 0, 0, 0));
        directed.push_back(make_cfg(REG_ROWS, 63));
        directed.push_back(make_cfg(REG_COLS, 32));
        directed.push_back(make_req(CMD_SEARCH, 31, 31, 3, 29, 30, 0, 0));
        directed.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(CMD_WRITE, 31, 31, 0, 0, 0, TER_A, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (i == 3)
                idle_mode = 3;
            else if (i == 1027)
                idle_mode = 0;
            issue_request(directed[i]);
        end
        for (int p = 0; p < 6; p++)
        begin
            idle_mode = p % 4;
            random_phase(45);
        end
        in_valid = 0;
        idle_mode = 0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
